FILE: hdl/psol_pkg.sv
// package: shared types and codes of the open list
`default_nettype none

package psol_pkg;

  // command codes of an input item
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } psol_cmd_e;

  // result status codes
  typedef enum logic [2:0] {
    STAT_DONE    = 3'd0,
    STAT_UPDATED = 3'd1,
    STAT_KEPT    = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_EMPTY   = 3'd4
  } psol_status_e;

  // sequencer states
  typedef enum logic [2:0] {
    PS_IDLE,
    PS_SCAN,
    PS_APPEND,
    PS_MOVE,
    PS_FINISH
  } psol_state_e;

  // input item
  typedef struct packed {
    logic        command;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [15:0] cost_h;
    logic [15:0] cost_g;
  } psol_in_t;

  // result item
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_x;
    logic [7:0]  out_y;
    logic [15:0] out_h;
    logic [15:0] out_g;
    logic [16:0] out_f;
    logic [8:0]  entries_held;
  } psol_out_t;

  // flags from the compare unit to the sequencer
  typedef struct packed {
    logic hit;       // read entry holds the pushed cell
    logic keep_old;  // held total is less than the pushed total
    logic better;    // read entry beats the current best
  } psol_flags_t;

endpackage

`default_nettype wire

FILE: hdl/psol_store.sv
// entry memory: one write port, one registered read port
`default_nettype none

module psol_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/psol_unit.sv
// shared compare unit: total of the read entry, cell match and ordering tests
`default_nettype none

module psol_unit
  import psol_pkg::*;
#(
  parameter int CW = 8,
  parameter int KW = 16
) (
  input  wire logic [2*CW+2*KW-1:0] rd_entry_i,
  input  wire logic [CW-1:0]        item_x_i,
  input  wire logic [CW-1:0]        item_y_i,
  input  wire logic [KW:0]          item_f_i,
  input  wire logic [KW-1:0]        best_h_i,
  input  wire logic [KW:0]          best_f_i,
  output logic      [KW:0]          rd_f_o,
  output psol_flags_t               flags_o
);

  localparam int EW = 2*CW + 2*KW;

  logic [CW-1:0] rd_x;
  logic [CW-1:0] rd_y;
  logic [KW-1:0] rd_h;
  logic [KW-1:0] rd_g;

  // unpack the entry
  assign rd_x = rd_entry_i[EW-1 -: CW];
  assign rd_y = rd_entry_i[EW-CW-1 -: CW];
  assign rd_h = rd_entry_i[2*KW-1 -: KW];
  assign rd_g = rd_entry_i[KW-1:0];

  // total cost of the read entry
  assign rd_f_o = {1'b0, rd_h} + {1'b0, rd_g};

  // match and ordering
  always_comb begin
    flags_o.hit      = (rd_x == item_x_i) && (rd_y == item_y_i);
    flags_o.keep_old = (rd_f_o < item_f_i);
    flags_o.better   = (rd_f_o < best_f_i) || ((rd_f_o == best_f_i) && (rd_h < best_h_i));
  end

endmodule

`default_nettype wire

FILE: hdl/psol_ctrl.sv
// sequencer: scans the store one entry per cycle and builds the result
`default_nettype none

module psol_ctrl
  import psol_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int CW       = 8,
  parameter int KW       = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire psol_in_t                    in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output psol_out_t                        out_data_o,
  // store ports
  output logic                             we_o,
  output logic [$clog2(CAPACITY)-1:0]      waddr_o,
  output logic [2*CW+2*KW-1:0]             wdata_o,
  output logic [$clog2(CAPACITY)-1:0]      raddr_o,
  input  wire logic [2*CW+2*KW-1:0]        rdata_i,
  // compare unit ports
  output logic [CW-1:0]                    item_x_o,
  output logic [CW-1:0]                    item_y_o,
  output logic [KW:0]                      item_f_o,
  output logic [KW-1:0]                    best_h_o,
  output logic [KW:0]                      best_f_o,
  input  wire logic [KW:0]                 rd_f_i,
  input  wire psol_flags_t                 flags_i
);

  localparam int IW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EW    = 2*CW + 2*KW;

  psol_state_e        state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   iss_q, iss_d;
  logic [CNT_W-1:0]   chk_q, chk_d;
  logic               rvalid_q, rvalid_d;
  psol_cmd_e          cmd_q, cmd_d;
  logic [CW-1:0]      item_x_q, item_x_d;
  logic [CW-1:0]      item_y_q, item_y_d;
  logic [KW-1:0]      item_h_q, item_h_d;
  logic [KW-1:0]      item_g_q, item_g_d;
  logic [KW:0]        item_f_q, item_f_d;
  logic [EW-1:0]      best_e_q, best_e_d;
  logic [KW:0]        best_f_q, best_f_d;
  logic [IW-1:0]      best_idx_q, best_idx_d;
  logic [EW-1:0]      move_q, move_d;
  psol_status_e       status_q, status_d;
  logic               out_valid_q, out_valid_d;
  psol_out_t          out_q, out_d;

  logic               last_chk;
  logic               taken;
  logic [CW-1:0]      best_x;
  logic [CW-1:0]      best_y;
  logic [KW-1:0]      best_g;

  assign best_x   = best_e_q[EW-1 -: CW];
  assign best_y   = best_e_q[EW-CW-1 -: CW];
  assign best_h_o = best_e_q[2*KW-1 -: KW];
  assign best_g   = best_e_q[KW-1:0];
  assign best_f_o = best_f_q;
  assign item_x_o = item_x_q;
  assign item_y_o = item_y_q;
  assign item_f_o = item_f_q;

  assign last_chk = (chk_q == cnt_q - CNT_W'(1));
  assign taken    = (chk_q == '0) || flags_i.better;
  assign raddr_o  = iss_q[IW-1:0];

  assign in_stall_o  = (state_q != PS_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PS_IDLE;
      cnt_q       <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    iss_q      <= iss_d;
    chk_q      <= chk_d;
    cmd_q      <= cmd_d;
    item_x_q   <= item_x_d;
    item_y_q   <= item_y_d;
    item_h_q   <= item_h_d;
    item_g_q   <= item_g_d;
    item_f_q   <= item_f_d;
    best_e_q   <= best_e_d;
    best_f_q   <= best_f_d;
    best_idx_q <= best_idx_d;
    move_q     <= move_d;
    status_q   <= status_d;
    out_q      <= out_d;
  end

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    chk_d       = chk_q;
    rvalid_d    = 1'b0;
    cmd_d       = cmd_q;
    item_x_d    = item_x_q;
    item_y_d    = item_y_q;
    item_h_d    = item_h_q;
    item_g_d    = item_g_q;
    item_f_d    = item_f_q;
    best_e_d    = best_e_q;
    best_f_d    = best_f_q;
    best_idx_d  = best_idx_q;
    move_d      = move_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    we_o        = 1'b0;
    waddr_o     = cnt_q[IW-1:0];
    wdata_o     = {item_x_q, item_y_q, item_h_q, item_g_q};

    // output register drains on transfer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      PS_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = psol_cmd_e'(in_data_i.command);
          item_x_d = CW'(in_data_i.cell_x);
          item_y_d = CW'(in_data_i.cell_y);
          item_h_d = KW'(in_data_i.cost_h);
          item_g_d = KW'(in_data_i.cost_g);
          item_f_d = {1'b0, KW'(in_data_i.cost_h)} + {1'b0, KW'(in_data_i.cost_g)};
          iss_d    = '0;
          chk_d    = '0;
          if (cnt_q == '0) begin
            if (in_data_i.command == CMD_POP) begin
              status_d = STAT_EMPTY;
              state_d  = PS_FINISH;
            end else begin
              state_d = PS_APPEND;
            end
          end else begin
            state_d = PS_SCAN;
          end
        end
      end

      PS_SCAN: begin
        // issue one read a cycle over the held slots
        if (iss_q != cnt_q) begin
          rvalid_d = 1'b1;
          iss_d    = iss_q + CNT_W'(1);
        end
        // check the entry read last cycle
        if (rvalid_q) begin
          chk_d = chk_q + CNT_W'(1);
          if (cmd_q == CMD_PUSH) begin
            if (flags_i.hit) begin
              rvalid_d = 1'b0;
              state_d  = PS_FINISH;
              if (flags_i.keep_old) begin
                status_d = STAT_KEPT;
              end else begin
                we_o     = 1'b1;
                waddr_o  = chk_q[IW-1:0];
                wdata_o  = {rdata_i[EW-1 -: 2*CW], item_h_q, item_g_q};
                status_d = STAT_UPDATED;
              end
            end else if (last_chk) begin
              rvalid_d = 1'b0;
              state_d  = PS_APPEND;
            end
          end else begin
            if (taken) begin
              best_e_d   = rdata_i;
              best_f_d   = rd_f_i;
              best_idx_d = chk_q[IW-1:0];
            end
            // the final slot read is the one that fills the hole
            if (last_chk) begin
              move_d   = rdata_i;
              rvalid_d = 1'b0;
              state_d  = PS_MOVE;
            end
          end
        end
      end

      PS_APPEND: begin
        if (cnt_q == CNT_W'(CAPACITY)) begin
          status_d = STAT_FULL;
        end else begin
          we_o     = 1'b1;
          cnt_d    = cnt_q + CNT_W'(1);
          status_d = STAT_DONE;
        end
        state_d = PS_FINISH;
      end

      PS_MOVE: begin
        we_o     = 1'b1;
        waddr_o  = best_idx_q;
        wdata_o  = move_q;
        cnt_d    = cnt_q - CNT_W'(1);
        status_d = STAT_DONE;
        state_d  = PS_FINISH;
      end

      PS_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d              = '0;
          out_d.status       = status_q;
          out_d.entries_held = 9'(cnt_q);
          if (cmd_q == CMD_POP && status_q == STAT_DONE) begin
            out_d.out_x = 8'(best_x);
            out_d.out_y = 8'(best_y);
            out_d.out_h = 16'(best_h_o);
            out_d.out_g = 16'(best_g);
            out_d.out_f = 17'(best_f_q);
          end
          out_valid_d = 1'b1;
          state_d     = PS_IDLE;
        end
      end

      default: begin
        state_d = PS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/path_search_open_list.sv
// top level of the open list for grid path search
//
//   channel | direction | signals                          | payload
//   in      | to block  | in_valid_i, in_stall_o           | psol_in_t in_data_i
//   out     | from block| out_valid_o, out_stall_i         | psol_out_t out_data_o
//
// A push scans the held slots one per cycle until the cell is found, else appends it
// if there is room. A pop scans all held slots and then moves the last entry into the
// popped slot; an empty pop goes straight to its result. The single read port of the entry memory sets
// the scan pace. Reset clears the count; the memory needs no clearing. The block takes
// one item at a time; a finished result waits in the output register while the next
// item is taken, and a stalled output holds back only the following result.
`default_nettype none

module path_search_open_list
  import psol_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int COORD_BITS = 8,
  parameter int COST_BITS  = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire psol_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output psol_out_t      out_data_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int EW = 2*COORD_BITS + 2*COST_BITS;

  logic                  we;
  logic [IW-1:0]         waddr;
  logic [EW-1:0]         wdata;
  logic [IW-1:0]         raddr;
  logic [EW-1:0]         rdata;
  logic [COORD_BITS-1:0] item_x;
  logic [COORD_BITS-1:0] item_y;
  logic [COST_BITS:0]    item_f;
  logic [COST_BITS-1:0]  best_h;
  logic [COST_BITS:0]    best_f;
  logic [COST_BITS:0]    rd_f;
  psol_flags_t           flags;

  // sequencer
  psol_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (COORD_BITS),
    .KW       (COST_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .item_x_o    (item_x),
    .item_y_o    (item_y),
    .item_f_o    (item_f),
    .best_h_o    (best_h),
    .best_f_o    (best_f),
    .rd_f_i      (rd_f),
    .flags_i     (flags)
  );

  // entry memory
  psol_store #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // shared compare unit
  psol_unit #(
    .CW (COORD_BITS),
    .KW (COST_BITS)
  ) u_unit (
    .rd_entry_i (rdata),
    .item_x_i   (item_x),
    .item_y_i   (item_y),
    .item_f_i   (item_f),
    .best_h_i   (best_h),
    .best_f_i   (best_f),
    .rd_f_o     (rd_f),
    .flags_o    (flags)
  );

endmodule

`default_nettype wire

FILE: hdl/psol_checker.sv
// port checker for the open list and its bind
`default_nettype none

module psol_checker
  import psol_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire psol_out_t out_data_o
);

  // a stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // one item at a time: busy right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // an empty pop leaves nothing held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_EMPTY |-> out_data_o.entries_held == 9'd0)
    else $error("empty pop with entries held");

  // only a popped entry carries cell data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STAT_UPDATED || out_data_o.status == STAT_KEPT ||
                    out_data_o.status == STAT_FULL || out_data_o.status == STAT_EMPTY)
    |-> out_data_o.out_f == 17'd0 && out_data_o.out_x == 8'd0 && out_data_o.out_y == 8'd0)
    else $error("cell data on a result that pops nothing");

endmodule

bind path_search_open_list psol_checker u_psol_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
